@@ src/torque_sensor_frame_deframer_core_macros.svh @@
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Clocked assertion helpers for the torque sensor deframer; they expect
// signals named clk and rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef TORQUE_SENSOR_FRAME_DEFRAMER_CORE_MACROS_SVH
`define TORQUE_SENSOR_FRAME_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define TSFD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TSFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TSFD_ASSERT_IMPLY(label, ante, cons, msg)
`define TSFD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ src/tsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Deframer package
// Step codes, control word layout and the sequencer program of the deframer.
// ----------------------------------------------------------------------------
package tsfd_pkg;

    localparam int unsigned WindowDepth = 8;
    localparam logic [15:0] CrcInit     = 16'hFFFF;
    localparam logic [15:0] CrcPoly     = 16'hA001;

    typedef enum logic [2:0] {
        STEP_WAIT   = 3'd0,
        STEP_CHECK  = 3'd1,
        STEP_XOR    = 3'd2,
        STEP_SHIFT  = 3'd3,
        STEP_NEXT   = 3'd4,
        STEP_RESULT = 3'd5,
        STEP_DROP   = 3'd6
    } step_t;

    typedef enum logic [2:0] {
        COND_NEXT       = 3'd0,
        COND_JUMP       = 3'd1,
        COND_NO_REQ     = 3'd2,
        COND_SHORT      = 3'd3,
        COND_BITS_LEFT  = 3'd4,
        COND_BYTES_LEFT = 3'd5,
        COND_OUT_BUSY   = 3'd6
    } cond_t;

    typedef struct packed {
        logic  take_byte;
        logic  crc_init;
        logic  crc_xor;
        logic  crc_shift;
        logic  next_byte;
        logic  load_result;
        logic  drop;
        cond_t cond;
        step_t target;
    } ctrl_t;

    function automatic ctrl_t ucode_word(step_t s);
        ctrl_t w;
        w = '{take_byte: 1'b0, crc_init: 1'b0, crc_xor: 1'b0, crc_shift: 1'b0,
              next_byte: 1'b0, load_result: 1'b0, drop: 1'b0,
              cond: COND_JUMP, target: STEP_WAIT};
        case (s)
            STEP_WAIT:
            begin
                w.take_byte = 1'b1;
                w.cond      = COND_NO_REQ;
                w.target    = STEP_WAIT;
            end
            STEP_CHECK:
            begin
                w.crc_init = 1'b1;
                w.cond     = COND_SHORT;
                w.target   = STEP_WAIT;
            end
            STEP_XOR:
            begin
                w.crc_xor = 1'b1;
                w.cond    = COND_NEXT;
            end
            STEP_SHIFT:
            begin
                w.crc_shift = 1'b1;
                w.cond      = COND_BITS_LEFT;
                w.target    = STEP_SHIFT;
            end
            STEP_NEXT:
            begin
                w.next_byte = 1'b1;
                w.cond      = COND_BYTES_LEFT;
                w.target    = STEP_XOR;
            end
            STEP_RESULT:
            begin
                w.load_result = 1'b1;
                w.cond        = COND_OUT_BUSY;
                w.target      = STEP_RESULT;
            end
            STEP_DROP:
            begin
                w.drop   = 1'b1;
                w.cond   = COND_JUMP;
                w.target = STEP_WAIT;
            end
            default:
            begin
                w.cond   = COND_JUMP;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

@@ src/torque_sensor_frame_deframer_core.sv @@
// ----------------------------------------------------------------------------
// Torque sensor frame deframer
// Collects serial bytes into 6- or 8-byte frames, checks the Modbus CRC-16
// and emits torque/speed measurements or CRC-error results.
// ----------------------------------------------------------------------------
// Use: bytes enter on in_valid/in_ready with data_byte, one request each.
// Results leave on out_valid/out_ready through an output register.
// The user must write frame_mode (with cfg_wr_en/cfg_wr_data) only while the
// block is idle; the block itself does not enforce this. A byte that does
// not complete a frame goes through the check step back to the wait step.
// A byte that completes a frame starts a bit-serial CRC run over the payload
// bytes on the microcoded sequencer (an XOR step, shift steps and a next-byte
// step per byte), then loads the result and drops before the next byte.
// A CRC error drops the oldest byte; a good frame drops the whole frame.
// If the receiver stalls, the sequencer holds at the result step until the
// output register frees; bytes are accepted again only after that.
// Reset empties the window, selects six-byte frames and clears out_valid.
// ----------------------------------------------------------------------------
`include "torque_sensor_frame_deframer_core_macros.svh"

module torque_sensor_frame_deframer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic signed [23:0] torque_hundredths,
    output logic signed [24:0] speed_rpm,
    output logic [15:0]        received_crc,
    output logic [15:0]        computed_crc,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data
);
    import tsfd_pkg::*;

    step_t       step_reg, step_next;
    logic [3:0]  fill_count_reg, fill_count_next;
    logic        frame_mode_reg;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  byte_idx_reg;
    logic [2:0]  bit_cnt_reg;
    logic [15:0] crc_reg;
    logic [7:0]  window_reg [WindowDepth];

    logic               result_kind_reg;
    logic signed [23:0] torque_reg;
    logic signed [24:0] speed_reg;
    logic [15:0]        rx_crc_reg;
    logic [15:0]        calc_crc_reg;

    ctrl_t        ctrl;
    logic         accept;
    logic         out_busy;
    logic         cond_hit;
    logic         load;
    logic [3:0]   frame_len;
    logic [2:0]   last_idx;
    logic [15:0]  rx_crc;
    logic         mismatch;
    logic [15:0]  mag;
    logic [23:0]  torque_val;
    logic [24:0]  speed_val;

    always_comb
    begin
        ctrl      = ucode_word(step_reg);
        accept    = in_valid && ctrl.take_byte;
        out_busy  = out_valid_reg && !out_ready;
        load      = ctrl.load_result && !out_busy;
        frame_len = frame_mode_reg ? 4'd8 : 4'd6;
        last_idx  = frame_mode_reg ? 3'd5 : 3'd3;
        rx_crc    = frame_mode_reg ? {window_reg[7], window_reg[6]}
                                   : {window_reg[5], window_reg[4]};
        mismatch  = (rx_crc != crc_reg);
        mag       = {window_reg[1], window_reg[0]};

        if (frame_mode_reg)
        begin
            torque_val = {window_reg[2], window_reg[1], window_reg[0]};
            speed_val  = {1'b0, window_reg[5], window_reg[4], window_reg[3]};
        end
        else
        begin
            torque_val = window_reg[2][7] ? (24'd0 - {8'd0, mag}) : {8'd0, mag};
            speed_val  = {{9{window_reg[3][7]}}, window_reg[3], 1'b0, window_reg[2][6:0]};
        end

        case (ctrl.cond)
            COND_NEXT:       cond_hit = 1'b0;
            COND_JUMP:       cond_hit = 1'b1;
            COND_NO_REQ:     cond_hit = !in_valid;
            COND_SHORT:      cond_hit = (fill_count_reg < frame_len);
            COND_BITS_LEFT:  cond_hit = (bit_cnt_reg != 3'd7);
            COND_BYTES_LEFT: cond_hit = (byte_idx_reg != last_idx);
            COND_OUT_BUSY:   cond_hit = out_busy;
            default:         cond_hit = 1'b1;
        endcase
        step_next = cond_hit ? ctrl.target : step_t'(step_reg + 3'd1);

        fill_count_next = fill_count_reg;
        if (accept && (fill_count_reg < 4'(WindowDepth)))
        begin
            fill_count_next = fill_count_reg + 4'd1;
        end
        else if (ctrl.drop)
        begin
            if (mismatch)
            begin
                fill_count_next = fill_count_reg - 4'd1;
            end
            else if (frame_len >= fill_count_reg)
            begin
                fill_count_next = 4'd0;
            end
            else
            begin
                fill_count_next = fill_count_reg - frame_len;
            end
        end

        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_WAIT;
            fill_count_reg <= 4'd0;
            frame_mode_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            fill_count_reg <= fill_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                frame_mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (fill_count_reg < 4'(WindowDepth)))
        begin
            window_reg[fill_count_reg[2:0]] <= data_byte;
        end
        else if (ctrl.drop)
        begin
            // advance the window by one byte or by a six-byte frame
            if (mismatch)
            begin
                for (int i = 0; i < WindowDepth - 1; i++)
                begin
                    window_reg[i] <= window_reg[i + 1];
                end
            end
            else if (!frame_mode_reg)
            begin
                window_reg[0] <= window_reg[6];
                window_reg[1] <= window_reg[7];
            end
        end

        if (ctrl.crc_init)
        begin
            crc_reg      <= CrcInit;
            byte_idx_reg <= 3'd0;
        end
        if (ctrl.crc_xor)
        begin
            crc_reg     <= crc_reg ^ {8'd0, window_reg[byte_idx_reg]};
            bit_cnt_reg <= 3'd0;
        end
        if (ctrl.crc_shift)
        begin
            crc_reg     <= crc_reg[0] ? ((crc_reg >> 1) ^ CrcPoly) : (crc_reg >> 1);
            bit_cnt_reg <= bit_cnt_reg + 3'd1;
        end
        if (ctrl.next_byte)
        begin
            byte_idx_reg <= byte_idx_reg + 3'd1;
        end

        if (load)
        begin
            result_kind_reg <= mismatch;
            torque_reg      <= mismatch ? 24'sd0 : signed'(torque_val);
            speed_reg       <= mismatch ? 25'sd0 : signed'(speed_val);
            rx_crc_reg      <= rx_crc;
            calc_crc_reg    <= crc_reg;
        end
    end

    assign in_ready          = ctrl.take_byte;
    assign out_valid         = out_valid_reg;
    assign result_kind       = result_kind_reg;
    assign torque_hundredths = torque_reg;
    assign speed_rpm         = speed_reg;
    assign received_crc      = rx_crc_reg;
    assign computed_crc      = calc_crc_reg;

    `TSFD_ASSERT_IMPLY(a_fill_bound, 1'b1, fill_count_reg <= 4'd8, "window fill above depth")
    `TSFD_ASSERT_IMPLY(a_no_full_req, in_valid && in_ready, fill_count_reg < 4'd8,
                       "request accepted with a full window")
    `TSFD_ASSERT_NEXT(a_load_shows, step_reg == STEP_RESULT && !out_busy, out_valid_reg,
                      "result load not visible")
    `TSFD_ASSERT_IMPLY(a_idx_bound, step_reg == STEP_SHIFT, byte_idx_reg <= last_idx,
                       "CRC byte index past payload")

endmodule
